// ----- rtl/core/merged_interval_set_defines.svh -----
// Assertion macros for the merged interval set checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef MERGED_INTERVAL_SET_DEFINES_SVH
`define MERGED_INTERVAL_SET_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MIS_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MIS_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ----- rtl/core/mis_pkg.sv -----
// Shared types and constants for the merged interval set.
// No dependencies.
package mis_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W        = 32;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_FIND   = 3'd2,
    OP_ISECT  = 3'd3,
    OP_TEST   = 3'd4,
    OP_LIST   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PLAN,
    S_MOVE,
    S_WRPC,
    S_EMIT_RD,
    S_EMIT_WT,
    S_EMIT_HOLD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [2:0] op;
    val_t       range_low;
    val_t       range_high;
  } in_item_t;

  typedef struct packed {
    val_t       item_low;
    val_t       item_high;
    logic       item_valid;
    logic [1:0] status;
    logic       last_item;
  } out_item_t;

endpackage

// ----- rtl/core/merged_interval_set.sv -----
// Merged interval set top level: sorted interval table in block memory.
// Depends on mis_pkg.
//
// One transaction at a time. Every operation except list, bad ranges and
// unused op codes first scans the stored entries, one memory read per cycle,
// then passes through the plan state. An update then shifts the tail of the
// table one entry per cycle, writes up to two new entries, and answers from
// the response state. Find, intersect and list emit their results one at a
// time, each through a read, a wait and a hold state, and hold a result while
// the output is stalled. Bad ranges and unused op codes go straight to the
// response state. The interval memory has a single read port. The table is
// empty after reset; no clearing pass is needed.
module merged_interval_set #(
  parameter int CAPACITY = mis_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mis_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mis_pkg::out_item_t out_data
);
  import mis_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Interval memory
  val_t mem_lo [CAPACITY];
  val_t mem_hi [CAPACITY];
  val_t rd_lo_r, rd_hi_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  val_t          wr_lo, wr_hi;

  // Control state
  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic out_vld_r, out_vld_nxt;
  logic scan_dv_r, scan_dv_nxt;
  logic mv_pend_r, mv_pend_nxt;

  // Operation registers
  logic [2:0] op_r, op_nxt;
  val_t a_r, a_nxt, b_r, b_nxt;
  logic [CW-1:0] f_r, f_nxt, e_r, e_nxt;
  logic got_f_r, got_f_nxt, got_e_r, got_e_nxt;
  val_t lowf_r, lowf_nxt, highl_r, highl_nxt;
  logic [CW-1:0] scan_ptr_r, scan_ptr_nxt, scan_q_r, scan_q_nxt;
  logic signed [CW:0] delta_r, delta_nxt;
  logic [CW-1:0] cnt_new_r, cnt_new_nxt;
  logic [CW-1:0] mv_src_r, mv_src_nxt, mv_left_r, mv_left_nxt, mv_dst_r, mv_dst_nxt;
  logic [1:0] pc_n_r, pc_n_nxt, pc_idx_r, pc_idx_nxt;
  val_t pc_lo_r [2];
  val_t pc_hi_r [2];
  val_t pc_lo_nxt [2];
  val_t pc_hi_nxt [2];
  logic resp_valid_r, resp_valid_nxt;
  logic [1:0] resp_status_r, resp_status_nxt;
  logic [CW-1:0] emit_ptr_r, emit_ptr_nxt;
  out_item_t out_r, out_nxt;

  // Shared decisions
  logic acc_in, in_bad, in_scan;
  logic scan_done, mv_done, wr_done, emit_last, out_taken;
  logic hit, add_full, rm_full, nl, nr, plan_move, plan_emit;
  logic [CW-1:0] span, tail;
  logic [1:0] n_pl;
  logic signed [CW:0] delta_pl;
  logic signed [CW+1:0] newcnt;
  logic [CW-1:0] mv_dst_w;

  assign out_taken = out_vld_r && !out_stall;
  assign in_stall  = !(state_r == S_IDLE && (!out_vld_r || !out_stall));
  assign acc_in    = in_valid && !in_stall;
  assign in_bad    = (in_data.op <= OP_TEST) && (in_data.range_low > in_data.range_high);
  assign in_scan   = in_data.op <= OP_TEST;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign scan_done = (scan_ptr_r >= count_r) && !scan_dv_r;
  assign mv_done   = (mv_left_r == '0) && !mv_pend_r;
  assign wr_done   = pc_idx_r >= pc_n_r;
  assign emit_last = (CW'(emit_ptr_r + 1'b1) == e_r);

  // Plan of an update after the scan
  assign hit      = f_r != e_r;
  assign span     = e_r - f_r;
  assign tail     = count_r - e_r;
  assign add_full = !hit && (count_r >= CW'(CAPACITY));
  assign nl       = lowf_r < a_r;
  assign nr       = highl_r > b_r;
  assign n_pl     = (op_r == OP_ADD) ? 2'd1 : ({1'b0, nl} + {1'b0, nr});
  assign delta_pl = $signed({{(CW-1){1'b0}}, n_pl}) - $signed({1'b0, span});
  assign newcnt   = $signed({2'b00, count_r}) + {delta_pl[CW], delta_pl};
  assign rm_full  = hit && (newcnt > $signed((CW+2)'(CAPACITY)));
  assign plan_move = (op_r == OP_ADD && !add_full) ||
                     (op_r == OP_REMOVE && hit && !rm_full);
  assign plan_emit = hit && (op_r == OP_FIND || op_r == OP_ISECT || op_r == OP_LIST);
  assign mv_dst_w  = CW'($signed({1'b0, mv_src_r}) + delta_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (in_bad) state_nxt = S_RESP;
          else if (in_data.op == OP_LIST) state_nxt = S_PLAN;
          else if (in_scan) state_nxt = S_SCAN;
          else state_nxt = S_RESP;
        end
      end
      S_SCAN:      if (scan_done) state_nxt = S_PLAN;
      S_PLAN: begin
        if (plan_move) state_nxt = S_MOVE;
        else if (plan_emit) state_nxt = S_EMIT_RD;
        else state_nxt = S_RESP;
      end
      S_MOVE:      if (mv_done) state_nxt = S_WRPC;
      S_WRPC:      if (wr_done) state_nxt = S_RESP;
      S_EMIT_RD:   state_nxt = S_EMIT_WT;
      S_EMIT_WT:   state_nxt = S_EMIT_HOLD;
      S_EMIT_HOLD: begin
        if (!out_stall) state_nxt = out_r.last_item ? S_IDLE : S_EMIT_RD;
      end
      S_RESP:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    count_nxt = count_r;      out_vld_nxt = out_vld_r;   scan_dv_nxt = 1'b0;
    mv_pend_nxt = 1'b0;       op_nxt = op_r;             a_nxt = a_r;
    b_nxt = b_r;              f_nxt = f_r;               e_nxt = e_r;
    got_f_nxt = got_f_r;      got_e_nxt = got_e_r;       lowf_nxt = lowf_r;
    highl_nxt = highl_r;      scan_ptr_nxt = scan_ptr_r; scan_q_nxt = scan_q_r;
    delta_nxt = delta_r;      cnt_new_nxt = cnt_new_r;   mv_src_nxt = mv_src_r;
    mv_left_nxt = mv_left_r;  mv_dst_nxt = mv_dst_r;     pc_n_nxt = pc_n_r;
    pc_idx_nxt = pc_idx_r;    pc_lo_nxt = pc_lo_r;       pc_hi_nxt = pc_hi_r;
    resp_valid_nxt = resp_valid_r;  resp_status_nxt = resp_status_r;
    emit_ptr_nxt = emit_ptr_r;      out_nxt = out_r;
    rd_addr = '0;  wr_en = 1'b0;  wr_addr = '0;  wr_lo = '0;  wr_hi = '0;

    if (out_taken) out_vld_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          op_nxt = in_data.op;  a_nxt = in_data.range_low;  b_nxt = in_data.range_high;
          f_nxt = (in_data.op == OP_LIST) ? '0 : count_r;
          e_nxt = count_r;
          got_f_nxt = 1'b0;  got_e_nxt = 1'b0;  scan_ptr_nxt = '0;
          resp_valid_nxt = 1'b0;
          resp_status_nxt = in_bad ? ST_BAD : ST_OK;
        end
      end
      // Sequential scan for the overlapping span [f, e)
      S_SCAN: begin
        rd_addr = AW'(scan_ptr_r);
        if (scan_ptr_r < count_r) begin
          scan_ptr_nxt = scan_ptr_r + 1'b1;
          scan_dv_nxt  = 1'b1;
          scan_q_nxt   = scan_ptr_r;
        end
        if (scan_dv_r) begin
          if (!got_f_r) begin
            if (rd_hi_r >= a_r) begin
              got_f_nxt = 1'b1;  f_nxt = scan_q_r;  lowf_nxt = rd_lo_r;
              if (rd_lo_r <= b_r) highl_nxt = rd_hi_r;
              else begin
                got_e_nxt = 1'b1;  e_nxt = scan_q_r;
              end
            end
          end else if (!got_e_r) begin
            if (rd_lo_r <= b_r) highl_nxt = rd_hi_r;
            else begin
              got_e_nxt = 1'b1;  e_nxt = scan_q_r;
            end
          end
        end
      end
      // Decide the update, pieces and tail shift
      S_PLAN: begin
        resp_valid_nxt = (op_r == OP_TEST) && hit;
        if (op_r == OP_ADD && add_full) resp_status_nxt = ST_FULL;
        if (op_r == OP_REMOVE && rm_full) resp_status_nxt = ST_FULL;
        delta_nxt   = delta_pl;
        cnt_new_nxt = CW'(newcnt);
        pc_n_nxt    = n_pl;
        pc_idx_nxt  = '0;
        emit_ptr_nxt = f_r;
        if (op_r == OP_ADD) begin
          pc_lo_nxt[0] = (hit && lowf_r < a_r) ? lowf_r : a_r;
          pc_hi_nxt[0] = (hit && highl_r > b_r) ? highl_r : b_r;
        end else begin
          pc_lo_nxt[0] = nl ? lowf_r : b_r + val_t'(1);
          pc_hi_nxt[0] = nl ? a_r - val_t'(1) : highl_r;
        end
        pc_lo_nxt[1] = b_r + val_t'(1);
        pc_hi_nxt[1] = highl_r;
        if (delta_pl > 0) begin
          mv_src_nxt = count_r - 1'b1;  mv_left_nxt = tail;
        end else if (delta_pl < 0) begin
          mv_src_nxt = e_r;  mv_left_nxt = tail;
        end else begin
          mv_src_nxt = e_r;  mv_left_nxt = '0;
        end
      end
      // Pipelined tail shift: read source, write destination next cycle
      S_MOVE: begin
        rd_addr = AW'(mv_src_r);
        if (mv_left_r != '0) begin
          mv_pend_nxt = 1'b1;
          mv_dst_nxt  = mv_dst_w;
          mv_left_nxt = mv_left_r - 1'b1;
          mv_src_nxt  = (delta_r > 0) ? mv_src_r - 1'b1 : mv_src_r + 1'b1;
        end
        if (mv_pend_r) begin
          wr_en = 1'b1;  wr_addr = AW'(mv_dst_r);  wr_lo = rd_lo_r;  wr_hi = rd_hi_r;
        end
      end
      // Write the new or trimmed entries at f
      S_WRPC: begin
        if (!wr_done) begin
          wr_en   = 1'b1;
          wr_addr = AW'(f_r + CW'(pc_idx_r));
          wr_lo   = pc_lo_r[pc_idx_r[0]];
          wr_hi   = pc_hi_r[pc_idx_r[0]];
          pc_idx_nxt = pc_idx_r + 1'b1;
        end else begin
          count_nxt = cnt_new_r;
        end
      end
      S_EMIT_RD: rd_addr = AW'(emit_ptr_r);
      S_EMIT_WT: begin
        out_nxt.item_low  = (op_r == OP_ISECT && rd_lo_r < a_r) ? a_r : rd_lo_r;
        out_nxt.item_high = (op_r == OP_ISECT && rd_hi_r > b_r) ? b_r : rd_hi_r;
        out_nxt.item_valid = 1'b1;
        out_nxt.status    = ST_OK;
        out_nxt.last_item = emit_last;
        out_vld_nxt = 1'b1;
      end
      S_EMIT_HOLD: begin
        if (!out_stall) emit_ptr_nxt = emit_ptr_r + 1'b1;
      end
      S_RESP: begin
        out_nxt.item_low   = '0;
        out_nxt.item_high  = '0;
        out_nxt.item_valid = resp_valid_r;
        out_nxt.status     = resp_status_r;
        out_nxt.last_item  = 1'b1;
        out_vld_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_lo[wr_addr] <= wr_lo;
      mem_hi[wr_addr] <= wr_hi;
    end
    rd_lo_r <= mem_lo[rd_addr];
    rd_hi_r <= mem_hi[rd_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      scan_dv_r <= 1'b0;
      mv_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      scan_dv_r <= scan_dv_nxt;
      mv_pend_r <= mv_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r <= op_nxt;  a_r <= a_nxt;  b_r <= b_nxt;
    f_r <= f_nxt;  e_r <= e_nxt;  got_f_r <= got_f_nxt;  got_e_r <= got_e_nxt;
    lowf_r <= lowf_nxt;  highl_r <= highl_nxt;
    scan_ptr_r <= scan_ptr_nxt;  scan_q_r <= scan_q_nxt;
    delta_r <= delta_nxt;  cnt_new_r <= cnt_new_nxt;
    mv_src_r <= mv_src_nxt;  mv_left_r <= mv_left_nxt;  mv_dst_r <= mv_dst_nxt;
    pc_n_r <= pc_n_nxt;  pc_idx_r <= pc_idx_nxt;
    pc_lo_r <= pc_lo_nxt;  pc_hi_r <= pc_hi_nxt;
    resp_valid_r <= resp_valid_nxt;  resp_status_r <= resp_status_nxt;
    emit_ptr_r <= emit_ptr_nxt;  out_r <= out_nxt;
  end

endmodule

// ----- rtl/core/mis_checker.sv -----
// Port-level checks for the merged interval set, bound to the top level.
// Depends on mis_pkg and merged_interval_set_defines.svh.
`include "merged_interval_set_defines.svh"

module mis_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mis_pkg::out_item_t out_data
);
  import mis_pkg::*;

  logic out_wait, in_take, out_err, out_mid;

  assign out_wait = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;
  assign out_err  = out_valid && (out_data.status != ST_OK);
  assign out_mid  = out_valid && !out_data.last_item;

  // A stalled result holds
  `MIS_ASSERT_NEXT(a_out_hold, out_wait, out_valid && $stable(out_data), "stalled result changed")
  // One transaction at a time: input closes right after acceptance
  `MIS_ASSERT_NEXT(a_in_busy, in_take, in_stall, "input accepted while busy")
  // Error statuses end the operation and carry no interval
  `MIS_ASSERT_NOW(a_err_last, out_err, out_data.last_item && !out_data.item_valid, "bad error result")
  // Results before the last always carry an interval
  `MIS_ASSERT_NOW(a_mid_valid, out_mid, out_data.item_valid, "intermediate result empty")

endmodule

bind merged_interval_set mis_checker u_mis_checker (.*);

// ----- tb/sv/merged_interval_set_checker.sv -----
// Checker for the merged interval set: watches both channels, predicts results.
// Depends on mis_pkg.
`timescale 1ns / 1ps

module merged_interval_set_checker #(
  parameter int CAPACITY = mis_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mis_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  mis_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending
);
  import mis_pkg::*;

  // shadow copy of the interval table
  longint tbl_lo[CAPACITY];
  longint tbl_hi[CAPACITY];
  int     tbl_n;
  out_item_t expected_q[$];

  function automatic out_item_t mk(longint lo, longint hi, logic v, status_t st, logic last);
    out_item_t r;
    r.item_low   = val_t'(lo);
    r.item_high  = val_t'(hi);
    r.item_valid = v;
    r.status     = st;
    r.last_item  = last;
    return r;
  endfunction

  // overlapping entries occupy [first, stop)
  task automatic find_span(longint a, longint b, output int first, output int stop);
    int i;
    i = 0;
    while (i < tbl_n && tbl_hi[i] < a) i++;
    first = i;
    while (i < tbl_n && tbl_lo[i] <= b) i++;
    stop = i;
  endtask

  task automatic apply_add(longint a, longint b, output status_t st);
    int f, e, i;
    find_span(a, b, f, e);
    st = ST_OK;
    if (f == e) begin
      if (tbl_n >= CAPACITY) begin
        st = ST_FULL;
        return;
      end
      for (i = tbl_n; i > f; i--) begin
        tbl_lo[i] = tbl_lo[i-1];
        tbl_hi[i] = tbl_hi[i-1];
      end
      tbl_lo[f] = a;
      tbl_hi[f] = b;
      tbl_n++;
      return;
    end
    if (tbl_lo[f] < a) a = tbl_lo[f];
    if (tbl_hi[e-1] > b) b = tbl_hi[e-1];
    tbl_lo[f] = a;
    tbl_hi[f] = b;
    for (i = e; i < tbl_n; i++) begin
      tbl_lo[f+1+i-e] = tbl_lo[i];
      tbl_hi[f+1+i-e] = tbl_hi[i];
    end
    tbl_n -= e - f - 1;
  endtask

  task automatic apply_remove(longint a, longint b, output status_t st);
    int f, e, i, n, cnt;
    longint pl[2];
    longint ph[2];
    longint tl[$];
    longint th[$];
    find_span(a, b, f, e);
    st = ST_OK;
    n = 0;
    if (f == e) return;
    if (tbl_lo[f] < a) begin
      pl[n] = tbl_lo[f]; ph[n] = a - 1; n++;
    end
    if (tbl_hi[e-1] > b) begin
      pl[n] = b + 1; ph[n] = tbl_hi[e-1]; n++;
    end
    cnt = tbl_n - (e - f) + n;
    if (cnt > CAPACITY) begin
      st = ST_FULL;
      return;
    end
    for (i = e; i < tbl_n; i++) begin
      tl.push_back(tbl_lo[i]);
      th.push_back(tbl_hi[i]);
    end
    for (i = 0; i < tl.size(); i++) begin
      tbl_lo[f+n+i] = tl[i];
      tbl_hi[f+n+i] = th[i];
    end
    for (i = 0; i < n; i++) begin
      tbl_lo[f+i] = pl[i];
      tbl_hi[f+i] = ph[i];
    end
    tbl_n = cnt;
  endtask

  // expected results of one operation
  task automatic predict(in_item_t t);
    longint a, b, lo, hi;
    int f, e, i, k;
    status_t st;
    a = longint'(t.range_low);
    b = longint'(t.range_high);
    k = 0;
    if (t.op <= 3'(OP_TEST) && a > b) begin
      expected_q.push_back(mk(0, 0, 1'b0, ST_BAD, 1'b1));
      return;
    end
    case (t.op)
      OP_ADD: begin
        apply_add(a, b, st);
        expected_q.push_back(mk(0, 0, 1'b0, st, 1'b1));
        k = 1;
      end
      OP_REMOVE: begin
        apply_remove(a, b, st);
        expected_q.push_back(mk(0, 0, 1'b0, st, 1'b1));
        k = 1;
      end
      OP_FIND, OP_ISECT: begin
        find_span(a, b, f, e);
        for (i = f; i < e; i++) begin
          lo = tbl_lo[i];
          hi = tbl_hi[i];
          if (t.op == 3'(OP_ISECT)) begin
            if (lo < a) lo = a;
            if (hi > b) hi = b;
          end
          expected_q.push_back(mk(lo, hi, 1'b1, ST_OK, i + 1 == e));
          k++;
        end
      end
      OP_TEST: begin
        find_span(a, b, f, e);
        expected_q.push_back(mk(0, 0, f != e, ST_OK, 1'b1));
        k = 1;
      end
      OP_LIST: begin
        for (i = 0; i < tbl_n; i++) begin
          expected_q.push_back(mk(tbl_lo[i], tbl_hi[i], 1'b1, ST_OK, i + 1 == tbl_n));
          k++;
        end
      end
      default: ;
    endcase
    if (k == 0) expected_q.push_back(mk(0, 0, 1'b0, ST_OK, 1'b1));
  endtask

  // watch both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      tbl_n = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result transaction %p", out_data);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_data.item_low !== want.item_low) begin
            $error("item_low: expected %0d, got %0d", want.item_low, out_data.item_low);
            fail_count++;
          end
          if (out_data.item_high !== want.item_high) begin
            $error("item_high: expected %0d, got %0d", want.item_high, out_data.item_high);
            fail_count++;
          end
          if (out_data.item_valid !== want.item_valid) begin
            $error("item_valid: expected %0b, got %0b", want.item_valid, out_data.item_valid);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fail_count++;
          end
          if (out_data.last_item !== want.last_item) begin
            $error("last_item: expected %0b, got %0b", want.last_item, out_data.last_item);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) predict(in_data);
    end
    // results still owed by the design
    pending = expected_q.size();
  end

endmodule

// ----- tb/sv/merged_interval_set_tb.sv -----
// Top of the merged interval set testbench: clock, reset, stimulus, verdict.
// Depends on mis_pkg, merged_interval_set and merged_interval_set_checker.
`timescale 1ns / 1ps

module merged_interval_set_tb;
  import mis_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  bit        calm = 1'b0;

  always #5 clk = ~clk;

  merged_interval_set dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  merged_interval_set_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver stalls in random bursts until the calm tail
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // one transaction; random gap before it; returns at the accepting edge
  task automatic send(logic [2:0] op, val_t lo, val_t hi);
    in_item_t t;
    int gap;
    t.op         = op;
    t.range_low  = lo;
    t.range_high = hi;
    gap = 0;
    if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic val_t rnd_val();
    case ($urandom_range(0, 3))
      0: return val_t'($urandom);
      default: return val_t'($urandom_range(0, 400)) - 200;
    endcase
  endfunction

  task automatic send_rand(logic [2:0] op);
    val_t a, b, t;
    a = rnd_val();
    b = ($urandom_range(0, 3) == 0) ? rnd_val() : a + val_t'($urandom_range(0, 20));
    if ($urandom_range(0, 9) != 0 && a > b) begin
      t = a; a = b; b = t;
    end
    send(op, a, b);
  endtask

  localparam val_t VMIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam val_t VMAX = {1'b0, {(VAL_W-1){1'b1}}};

  initial begin
    int i, r;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty table, extremes, merge, split, bad range, unused codes
    send(OP_LIST, 0, 0);
    send(OP_FIND, 0, 10);
    send(OP_ADD, VMIN, VMIN + 5);
    send(OP_ADD, VMAX - 5, VMAX);
    send(OP_ADD, 1, 2);
    send(OP_ADD, 3, 4);
    send(OP_ADD, 10, 20);
    send(OP_ADD, 2, 11);
    send(OP_LIST, 5, -5);
    send(OP_REMOVE, 5, 7);
    send(OP_FIND, 0, 12);
    send(OP_ISECT, 0, 12);
    send(OP_TEST, 5, 7);
    send(OP_TEST, 8, 8);
    send(OP_ADD, 9, 3);
    send(OP_REMOVE, VMAX, VMIN);
    send(3'd6, VMAX, VMIN);
    send(3'd7, -1, -1);
    send(OP_REMOVE, VMIN, VMAX);
    send(OP_LIST, 0, 0);

    // fill the table to capacity, then overflow it
    for (i = 0; i < CAPACITY_DEF; i++) send(OP_ADD, val_t'(i * 10), val_t'(i * 10 + 3));
    send(OP_ADD, 1000, 1001);
    send(OP_REMOVE, 1, 1);
    send(OP_LIST, 0, 0);
    send(OP_REMOVE, 0, 1000);

    // random: mostly small values so entries collide
    for (i = 0; i < 214; i++) begin
      if (i >= 180) calm = 1'b1;
      r = $urandom_range(0, 19);
      if (r < 7) send_rand(OP_ADD);
      else if (r < 10) send_rand(OP_REMOVE);
      else if (r < 12) send_rand(OP_FIND);
      else if (r < 14) send_rand(OP_ISECT);
      else if (r < 16) send_rand(OP_TEST);
      else if (r < 18) send_rand(OP_LIST);
      else if (r < 19) send_rand(3'($urandom_range(6, 7)));
      else send(3'($urandom), val_t'($urandom), val_t'($urandom));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // timeout guard
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
